/* src/ose_pkg.sv */
// ----------------------------------------------------------------------------
// ose_pkg
// Command, status and class codes shared by the operand stack engine files.
// ----------------------------------------------------------------------------
`default_nettype none

package ose_pkg;

    // Stream widths that do not vary with the stack parameters.
    localparam int IN_TDATA_W = 40;
    localparam int IN_TUSER_W = 4;
    localparam int PUSH_W     = 32;
    localparam int TOP_W      = 32;
    localparam int STATUS_W   = 3;
    localparam int CLASS_W    = 2;

    // Commands.
    localparam logic [3:0] CMD_PUSH  = 4'd0;
    localparam logic [3:0] CMD_POP   = 4'd1;
    localparam logic [3:0] CMD_EXCH  = 4'd2;
    localparam logic [3:0] CMD_DUP   = 4'd3;
    localparam logic [3:0] CMD_INDEX = 4'd4;
    localparam logic [3:0] CMD_CLEAR = 4'd5;
    localparam logic [3:0] CMD_COUNT = 4'd6;
    localparam logic [3:0] CMD_ROLL  = 4'd7;
    localparam logic [3:0] CMD_CTM   = 4'd8;
    localparam logic [3:0] CMD_CLM   = 4'd9;

    // Status codes.
    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_UNDER = 3'd1;
    localparam logic [2:0] ST_OVER  = 3'd2;
    localparam logic [2:0] ST_CLASS = 3'd3;
    localparam logic [2:0] ST_RANGE = 3'd4;

    // Element classes.
    localparam logic [1:0] CL_NULL   = 2'd0;
    localparam logic [1:0] CL_NUMBER = 2'd1;
    localparam logic [1:0] CL_MARK   = 2'd2;
    localparam logic [1:0] CL_OTHER  = 2'd3;

endpackage

`default_nettype wire

/* src/ose_ram.sv */
// ----------------------------------------------------------------------------
// ose_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ose_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 64
) (
    input  wire logic                       clk,
    input  wire logic                       we,
    input  wire logic [$clog2(DEPTH)-1:0]   waddr,
    input  wire logic [WIDTH-1:0]           wdata,
    input  wire logic [$clog2(DEPTH)-1:0]   raddr,
    output logic      [WIDTH-1:0]           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* src/operand_stack_engine.sv */
// ----------------------------------------------------------------------------
// operand_stack_engine
// Operand stack of tagged elements with push, pop, exch, dup, index, clear,
// count, roll, counttomark and cleartomark, each with full error checking.
// ----------------------------------------------------------------------------
// Usage:
//   A command word enters on the s_axis group, the command code in tuser and
//   the push class and value in tdata. Every command gives exactly one result
//   word on the m_axis group: status, depth and the top element.
//   The elements live in a RAM with a registered read; the top element is
//   also kept in registers, and the result word is built from them.
//   Push, dup, clear, count, pop to empty and unused codes do not read the
//   RAM; pop, index, exch and cleartomark with the mark on top read it once.
//   Roll of n elements makes one RAM pass that copies the elements into a
//   scratch RAM and a second pass that writes them back rotated.
//   Counttomark and cleartomark walk down one entry a cycle to the mark.
//   The result word is registered once the work ends and the output is
//   free. The block holds one word in work and one result word; while the
//   receiver stalls and a result word is held, a finished result waits and
//   no further command word is taken.
//   After reset the stack is empty. RAM contents are not cleared: only
//   entries below the depth are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module operand_stack_engine
    import ose_pkg::*;
#(
    parameter int STACK_DEPTH = 64,
    parameter int VALUE_BITS  = 32,
    localparam int CNT_W      = $clog2(STACK_DEPTH + 1),
    localparam int OUT_W      = STATUS_W + CNT_W + CLASS_W + TOP_W,
    localparam int OUT_TW     = ((OUT_W + 7) / 8) * 8
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    s_axis_tvalid,
    output logic                         s_axis_tready,
    // [1:0] push_class, [33:2] push_value, [39:34] zero
    input  wire logic [IN_TDATA_W-1:0]   s_axis_tdata,
    // [3:0] command
    input  wire logic [IN_TUSER_W-1:0]   s_axis_tuser,
    output logic                         m_axis_tvalid,
    input  wire logic                    m_axis_tready,
    // status, stack_count, top_class, top_value, zero fill (lowest bit up)
    output logic      [OUT_TW-1:0]       m_axis_tdata
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int VB = VALUE_BITS;
    localparam int EW = VB + CLASS_W;
    localparam int WS = ((VB > CNT_W) ? VB : CNT_W) + 2;
    localparam logic [CNT_W-1:0] FULL = CNT_W'(STACK_DEPTH);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_WAIT = 3'd2;
    localparam logic [2:0] S_WR2  = 3'd3;
    localparam logic [2:0] S_RCP  = 3'd4;
    localparam logic [2:0] S_RWR  = 3'd5;
    localparam logic [2:0] S_SCAN = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    function automatic logic [VB-1:0] cnt_to_val(input logic [CNT_W-1:0] c);
        logic [WS-1:0] w;
        w = {{(WS-CNT_W){1'b0}}, c};
        return w[VB-1:0];
    endfunction

    // Control state.
    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             m_valid_reg, m_valid_next;
    logic             dv_reg, dv_next;
    logic             more_reg, more_next;

    // Working registers.
    logic [3:0]       cmd_reg, cmd_next;
    logic [1:0]       pcls_reg, pcls_next;
    logic [VB-1:0]    pval_reg, pval_next;
    logic [2:0]       status_reg, status_next;
    logic [1:0]       top_cls_reg, top_cls_next;
    logic [VB-1:0]    top_val_reg, top_val_next;
    logic [AW-1:0]    cnt_reg, cnt_next;
    logic [AW-1:0]    base_reg, base_next;
    logic [AW-1:0]    src_reg, src_next;
    logic [AW-1:0]    rk_reg, rk_next;
    logic [AW-1:0]    wk_reg, wk_next;
    logic [OUT_TW-1:0] out_reg, out_next;

    // RAM ports.
    logic             mem_we;
    logic [AW-1:0]    mem_waddr, mem_raddr;
    logic [EW-1:0]    mem_wdata, mem_rdata;
    logic             buf_we;
    logic [AW-1:0]    buf_waddr, buf_raddr;
    logic [EW-1:0]    buf_wdata, buf_rdata;

    // Helpers.
    logic             out_free;
    logic             accept;
    logic [CNT_W-1:0] fill_m1, fill_m2;
    logic [1:0]       rd_cls;
    logic [VB-1:0]    rd_val;
    logic [63:0]      push64, top64;
    logic signed [WS-1:0] f_w, t_w, r_w, idx_addr_w, roll_base_w, sh_w;
    logic             idx_range, roll_range;
    logic [AW-1:0]    sh_a;
    logic             found;
    logic [AW-1:0]    found_pos;
    logic [CNT_W-1:0] found_cnt;

    ose_ram #(
        .WIDTH (EW),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Scratch copy for roll.
    ose_ram #(
        .WIDTH (EW),
        .DEPTH (STACK_DEPTH)
    ) u_roll_ram (
        .clk   (clk),
        .we    (buf_we),
        .waddr (buf_waddr),
        .wdata (buf_wdata),
        .raddr (buf_raddr),
        .rdata (buf_rdata)
    );

    assign out_free      = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE) || ((state_reg == S_DONE) && out_free);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = out_reg;

    assign fill_m1 = fill_reg - CNT_W'(1);
    assign fill_m2 = fill_reg - CNT_W'(2);
    assign rd_cls  = mem_rdata[EW-1:VB];
    assign rd_val  = mem_rdata[VB-1:0];
    assign push64  = {{(64-PUSH_W){s_axis_tdata[33]}}, s_axis_tdata[33:2]};
    assign top64   = {{(64-VB){top_val_reg[VB-1]}}, top_val_reg};

    // Signed operand views, wide enough to compare against the depth.
    assign f_w = {{(WS-CNT_W){1'b0}}, fill_reg};
    assign t_w = {{(WS-VB){top_val_reg[VB-1]}}, top_val_reg};
    assign r_w = {{(WS-VB){rd_val[VB-1]}}, rd_val};

    assign idx_range   = (t_w < 0) || (t_w > f_w - WS'(2));
    assign idx_addr_w  = f_w - WS'(2) - t_w;

    // For roll, r_w is n (second from top) and t_w is j (top).
    assign roll_range  = (r_w <= 0) || (t_w >= r_w) || ((t_w + r_w) <= 0)
                         || (r_w > f_w - WS'(2));
    assign roll_base_w = f_w - WS'(2) - r_w;
    assign sh_w        = (t_w < 0) ? (t_w + r_w) : t_w;
    assign sh_a        = sh_w[AW-1:0];

    always_comb
    begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        m_valid_next = m_valid_reg;
        dv_next      = 1'b0;
        more_next    = more_reg;
        cmd_next     = cmd_reg;
        pcls_next    = pcls_reg;
        pval_next    = pval_reg;
        status_next  = status_reg;
        top_cls_next = top_cls_reg;
        top_val_next = top_val_reg;
        cnt_next     = cnt_reg;
        base_next    = base_reg;
        src_next     = src_reg;
        rk_next      = rk_reg;
        wk_next      = wk_reg;
        out_next     = out_reg;
        mem_we       = 1'b0;
        mem_waddr    = fill_reg[AW-1:0];
        mem_wdata    = {top_cls_reg, top_val_reg};
        mem_raddr    = fill_m2[AW-1:0];
        buf_we       = 1'b0;
        buf_waddr    = wk_reg;
        buf_wdata    = mem_rdata;
        buf_raddr    = src_reg;
        found        = 1'b0;
        found_pos    = fill_m1[AW-1:0];

        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                // Nothing to do until a command word arrives.
            end

            S_EXEC:
            begin
                status_next = ST_OK;
                state_next  = S_DONE;
                unique case (cmd_reg) inside
                    CMD_PUSH:
                    begin
                        if (fill_reg == FULL)
                        begin
                            status_next = ST_OVER;
                        end
                        else
                        begin
                            mem_we       = 1'b1;
                            mem_wdata    = {pcls_reg, pval_reg};
                            top_cls_next = pcls_reg;
                            top_val_next = pval_reg;
                            fill_next    = fill_reg + CNT_W'(1);
                        end
                    end
                    CMD_POP:
                    begin
                        if (fill_reg == '0)
                        begin
                            status_next = ST_UNDER;
                        end
                        else
                        begin
                            fill_next = fill_m1;
                            if (fill_reg >= CNT_W'(2))
                            begin
                                state_next = S_WAIT;
                            end
                        end
                    end
                    CMD_EXCH:
                    begin
                        if (fill_reg < CNT_W'(2))
                        begin
                            status_next = ST_UNDER;
                        end
                        else
                        begin
                            state_next = S_WAIT;
                        end
                    end
                    CMD_DUP:
                    begin
                        if (fill_reg == '0)
                        begin
                            status_next = ST_UNDER;
                        end
                        else if (fill_reg == FULL)
                        begin
                            status_next = ST_OVER;
                        end
                        else
                        begin
                            mem_we    = 1'b1;
                            fill_next = fill_reg + CNT_W'(1);
                        end
                    end
                    CMD_INDEX:
                    begin
                        if (fill_reg == '0)
                        begin
                            status_next = ST_UNDER;
                        end
                        else if (top_cls_reg != CL_NUMBER)
                        begin
                            status_next = ST_CLASS;
                        end
                        else if (idx_range)
                        begin
                            status_next = ST_RANGE;
                        end
                        else
                        begin
                            mem_raddr  = idx_addr_w[AW-1:0];
                            state_next = S_WAIT;
                        end
                    end
                    CMD_CLEAR:
                    begin
                        fill_next = '0;
                    end
                    CMD_COUNT:
                    begin
                        if (fill_reg == FULL)
                        begin
                            status_next = ST_OVER;
                        end
                        else
                        begin
                            mem_we       = 1'b1;
                            mem_wdata    = {CL_NUMBER, cnt_to_val(fill_reg)};
                            top_cls_next = CL_NUMBER;
                            top_val_next = cnt_to_val(fill_reg);
                            fill_next    = fill_reg + CNT_W'(1);
                        end
                    end
                    CMD_ROLL:
                    begin
                        if (fill_reg < CNT_W'(3))
                        begin
                            status_next = ST_UNDER;
                        end
                        else
                        begin
                            state_next = S_WAIT;
                        end
                    end
                    CMD_CTM, CMD_CLM:
                    begin
                        if (fill_reg == '0)
                        begin
                            status_next = ST_UNDER;
                        end
                        else if (top_cls_reg == CL_MARK)
                        begin
                            found     = 1'b1;
                            found_pos = fill_m1[AW-1:0];
                        end
                        else if (fill_reg == CNT_W'(1))
                        begin
                            status_next = ST_UNDER;
                        end
                        else
                        begin
                            // Walk down from the entry below the top.
                            rk_next    = fill_m2[AW-1:0];
                            more_next  = 1'b1;
                            state_next = S_SCAN;
                        end
                    end
                    default:
                    begin
                        // Unused codes leave the stack as it is.
                    end
                endcase
            end

            S_WAIT:
            begin
                state_next = S_DONE;
                unique case (cmd_reg) inside
                    CMD_EXCH:
                    begin
                        mem_we       = 1'b1;
                        mem_waddr    = fill_m2[AW-1:0];
                        top_cls_next = rd_cls;
                        top_val_next = rd_val;
                        state_next   = S_WR2;
                    end
                    CMD_INDEX:
                    begin
                        mem_we       = 1'b1;
                        mem_waddr    = fill_m1[AW-1:0];
                        mem_wdata    = mem_rdata;
                        top_cls_next = rd_cls;
                        top_val_next = rd_val;
                    end
                    CMD_ROLL:
                    begin
                        if ((rd_cls != CL_NUMBER) || (top_cls_reg != CL_NUMBER))
                        begin
                            status_next = ST_CLASS;
                        end
                        else if (roll_range)
                        begin
                            status_next = ST_RANGE;
                        end
                        else
                        begin
                            cnt_next   = r_w[AW-1:0];
                            base_next  = roll_base_w[AW-1:0];
                            src_next   = (sh_a == '0) ? '0 : (r_w[AW-1:0] - sh_a);
                            rk_next    = '0;
                            state_next = S_RCP;
                        end
                    end
                    CMD_POP, CMD_CLM:
                    begin
                        top_cls_next = rd_cls;
                        top_val_next = rd_val;
                    end
                    default:
                    begin
                        // No other command comes to this state.
                    end
                endcase
            end

            S_WR2:
            begin
                // Second half of exch: the old top went one place down in the first half,
                // the new top (already in registers) now goes on top.
                mem_we     = 1'b1;
                mem_waddr  = fill_m1[AW-1:0];
                state_next = S_DONE;
            end

            S_RCP:
            begin
                if (rk_reg < cnt_reg)
                begin
                    mem_raddr = base_reg + rk_reg;
                    dv_next   = 1'b1;
                    wk_next   = rk_reg;
                    rk_next   = rk_reg + AW'(1);
                end
                if (dv_reg)
                begin
                    buf_we = 1'b1;
                    if (wk_reg == cnt_reg - AW'(1))
                    begin
                        rk_next    = '0;
                        dv_next    = 1'b0;
                        state_next = S_RWR;
                    end
                end
            end

            S_RWR:
            begin
                // Destination k takes the element that was at (k - shift) mod n.
                if (rk_reg < cnt_reg)
                begin
                    dv_next  = 1'b1;
                    wk_next  = rk_reg;
                    rk_next  = rk_reg + AW'(1);
                    src_next = (src_reg == cnt_reg - AW'(1)) ? '0 : (src_reg + AW'(1));
                end
                if (dv_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = base_reg + wk_reg;
                    mem_wdata = buf_rdata;
                    if (wk_reg == cnt_reg - AW'(1))
                    begin
                        top_cls_next = buf_rdata[EW-1:VB];
                        top_val_next = buf_rdata[VB-1:0];
                        fill_next    = fill_m2;
                        dv_next      = 1'b0;
                        state_next   = S_DONE;
                    end
                end
            end

            S_SCAN:
            begin
                if (more_reg)
                begin
                    mem_raddr = rk_reg;
                    dv_next   = 1'b1;
                    wk_next   = rk_reg;
                    if (rk_reg == '0)
                    begin
                        more_next = 1'b0;
                    end
                    else
                    begin
                        rk_next = rk_reg - AW'(1);
                    end
                end
                if (dv_reg)
                begin
                    if (rd_cls == CL_MARK)
                    begin
                        found     = 1'b1;
                        found_pos = wk_reg;
                    end
                    else if (wk_reg == '0)
                    begin
                        status_next = ST_UNDER;
                        state_next  = S_DONE;
                    end
                end
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    if (fill_reg == '0)
                    begin
                        out_next = OUT_TW'({TOP_W'(0), CL_NULL, fill_reg, status_reg});
                    end
                    else
                    begin
                        out_next = OUT_TW'({top64[TOP_W-1:0], top_cls_reg, fill_reg,
                                            status_reg});
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // A mark was found at found_pos.
        found_cnt = fill_m1 - {{(CNT_W-AW){1'b0}}, found_pos};
        if (found)
        begin
            status_next = ST_OK;
            dv_next     = 1'b0;
            state_next  = S_DONE;
            if (cmd_reg == CMD_CTM)
            begin
                if (fill_reg == FULL)
                begin
                    status_next = ST_OVER;
                end
                else
                begin
                    mem_we       = 1'b1;
                    mem_waddr    = fill_reg[AW-1:0];
                    mem_wdata    = {CL_NUMBER, cnt_to_val(found_cnt)};
                    top_cls_next = CL_NUMBER;
                    top_val_next = cnt_to_val(found_cnt);
                    fill_next    = fill_reg + CNT_W'(1);
                end
            end
            else
            begin
                fill_next = {{(CNT_W-AW){1'b0}}, found_pos};
                if (found_pos != '0)
                begin
                    mem_raddr  = found_pos - AW'(1);
                    state_next = S_WAIT;
                end
            end
        end

        if (accept)
        begin
            cmd_next   = s_axis_tuser[3:0];
            pcls_next  = s_axis_tdata[1:0];
            pval_next  = push64[VB-1:0];
            state_next = S_EXEC;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
            dv_reg      <= 1'b0;
            more_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
            dv_reg      <= dv_next;
            more_reg    <= more_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        pcls_reg    <= pcls_next;
        pval_reg    <= pval_next;
        status_reg  <= status_next;
        top_cls_reg <= top_cls_next;
        top_val_reg <= top_val_next;
        cnt_reg     <= cnt_next;
        base_reg    <= base_next;
        src_reg     <= src_next;
        rk_reg      <= rk_next;
        wk_reg      <= wk_next;
        out_reg     <= out_next;
    end

endmodule

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for operand_stack_engine. Command words are built ahead
// of time into a queue, using a private copy of the stack to steer each random
// sequence toward valid index, roll and mark operations, plus fill-to-full
// runs that hit overflow. A second copy of the stack predicts the result of
// every accepted word, and each result word is checked field by field.
// ----------------------------------------------------------------------------

module tb
    import ose_pkg::*;
();

    localparam int STACK_DEPTH = 64;
    localparam int CNT_W       = 7;
    localparam int RES_W       = 48;
    localparam int N_ITEMS     = 1800;
    localparam int DRAIN_AT    = 900;
    localparam int HOLD_AT     = 500;
    localparam int LONG_HOLD   = 400;
    localparam int STALL_LIMIT = 3000;
    localparam int TAIL_CYCLES = 200;

    // Two independent copies of the stack: one steers generation, one checks.
    localparam int GEN_VIEW = 0;
    localparam int CHK_VIEW = 1;

    localparam logic [3:0] CMD_SPARE_LO = CMD_CLM + 4'd1;
    localparam logic [3:0] CMD_SPARE_HI = 4'hF;

    typedef struct packed {
        logic       drain;
        logic [3:0] cmd;
        logic [1:0] cls;
        logic [31:0] val;
    } cmd_word_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CNT_W-1:0]    depth;
        logic [CLASS_W-1:0]  top_cls;
        logic [TOP_W-1:0]    top_val;
    } stack_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
    logic [IN_TUSER_W-1:0] s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [RES_W-1:0]      m_axis_tdata;

    logic [1:0]  stack_cls [2][STACK_DEPTH];
    logic [31:0] stack_val [2][STACK_DEPTH];
    int          stack_fill [2];

    cmd_word_t     cmd_q[$];
    stack_result_t pending_results[$];
    int            gen_count = 0;
    int            words_offered = 0;
    int            words_in = 0;
    int            results_seen = 0;
    int            err_count = 0;
    int            idle_cycles = 0;
    int            gap_left = 0;
    int            burst_left = 1;
    int            rx_mode = 0;
    int            mode_left = 0;
    int            rx_phase = 0;
    int            hold_left = 0;
    logic          long_hold_done = 1'b0;

    operand_stack_engine DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    function automatic logic [2:0] push_entry(int u, logic [1:0] cls, logic [31:0] val);
        if (stack_fill[u] >= STACK_DEPTH)
            return ST_OVER;
        stack_cls[u][stack_fill[u]] = cls;
        stack_val[u][stack_fill[u]] = val;
        stack_fill[u] = stack_fill[u] + 1;
        return ST_OK;
    endfunction

    function automatic stack_result_t run_command(int u, logic [3:0] cmd, logic [1:0] pcls,
                                                  logic [31:0] pval);
        stack_result_t r;
        int d;
        int pos;
        int n;
        int j;
        int sh;
        int base;
        logic [1:0]  tc;
        logic [31:0] tv;
        logic [1:0]  rc [STACK_DEPTH];
        logic [31:0] rv [STACK_DEPTH];
        r.status = ST_OK;
        d = stack_fill[u];
        pos = -1;
        if (cmd == CMD_CTM || cmd == CMD_CLM)
        begin
            for (int i = d - 1; i >= 0 && pos < 0; i--)
                if (stack_cls[u][i] == CL_MARK)
                    pos = i;
        end
        case (cmd)
            CMD_PUSH: r.status = push_entry(u, pcls, pval);
            CMD_POP:
            begin
                if (d < 1) r.status = ST_UNDER;
                else stack_fill[u] = d - 1;
            end
            CMD_EXCH:
            begin
                if (d < 2) r.status = ST_UNDER;
                else
                begin
                    tc = stack_cls[u][d-1];
                    tv = stack_val[u][d-1];
                    stack_cls[u][d-1] = stack_cls[u][d-2];
                    stack_val[u][d-1] = stack_val[u][d-2];
                    stack_cls[u][d-2] = tc;
                    stack_val[u][d-2] = tv;
                end
            end
            CMD_DUP:
            begin
                if (d < 1) r.status = ST_UNDER;
                else r.status = push_entry(u, stack_cls[u][d-1], stack_val[u][d-1]);
            end
            CMD_INDEX:
            begin
                if (d < 1) r.status = ST_UNDER;
                else if (stack_cls[u][d-1] != CL_NUMBER) r.status = ST_CLASS;
                else
                begin
                    n = $signed(stack_val[u][d-1]);
                    if (n < 0 || n > d - 2) r.status = ST_RANGE;
                    else
                    begin
                        stack_cls[u][d-1] = stack_cls[u][d-2-n];
                        stack_val[u][d-1] = stack_val[u][d-2-n];
                    end
                end
            end
            CMD_CLEAR: stack_fill[u] = 0;
            CMD_COUNT: r.status = push_entry(u, CL_NUMBER, d);
            CMD_ROLL:
            begin
                if (d < 3) r.status = ST_UNDER;
                else if (stack_cls[u][d-2] != CL_NUMBER || stack_cls[u][d-1] != CL_NUMBER)
                    r.status = ST_CLASS;
                else
                begin
                    n = $signed(stack_val[u][d-2]);
                    j = $signed(stack_val[u][d-1]);
                    if (n <= 0 || j >= n || j <= -n || n > d - 2) r.status = ST_RANGE;
                    else
                    begin
                        base = d - 2 - n;
                        sh = (j < 0) ? j + n : j;
                        for (int i = 0; i < n; i++)
                        begin
                            rc[i] = stack_cls[u][base+i];
                            rv[i] = stack_val[u][base+i];
                        end
                        for (int i = 0; i < n; i++)
                        begin
                            stack_cls[u][base + (i + sh) % n] = rc[i];
                            stack_val[u][base + (i + sh) % n] = rv[i];
                        end
                        stack_fill[u] = d - 2;
                    end
                end
            end
            CMD_CTM:
            begin
                if (pos < 0) r.status = ST_UNDER;
                else r.status = push_entry(u, CL_NUMBER, d - 1 - pos);
            end
            CMD_CLM:
            begin
                if (pos < 0) r.status = ST_UNDER;
                else stack_fill[u] = pos;
            end
            default: ;
        endcase
        r.depth = CNT_W'(stack_fill[u]);
        if (stack_fill[u] > 0)
        begin
            r.top_cls = stack_cls[u][stack_fill[u]-1];
            r.top_val = stack_val[u][stack_fill[u]-1];
        end
        else
        begin
            r.top_cls = CL_NULL;
            r.top_val = '0;
        end
        return r;
    endfunction

    function automatic void add_word(logic [3:0] cmd, logic [1:0] cls, logic [31:0] val);
        cmd_word_t w;
        w.drain = (gen_count == DRAIN_AT);
        w.cmd = cmd;
        w.cls = cls;
        w.val = val;
        cmd_q.push_back(w);
        void'(run_command(GEN_VIEW, cmd, cls, val));
        gen_count = gen_count + 1;
    endfunction

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [1:0] rand_class();
        return 2'($urandom_range(0, 3));
    endfunction

    // Sender: bursts of random length separated by random gaps.
    always @(negedge clk)
    begin : feed
        cmd_word_t w;
        int gap;
        if (rst_n && (!s_axis_tvalid || words_in == words_offered))
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (cmd_q.size() > 0 &&
                     !(cmd_q[0].drain && pending_results.size() != 0))
            begin
                w = cmd_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {6'b0, w.val, w.cls};
                s_axis_tuser <= w.cmd;
                words_offered <= words_offered + 1;
                if (burst_left <= 1)
                begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3: gap = 0;
                        9: gap = $urandom_range(10, 40);
                        default: gap = $urandom_range(1, 6);
                    endcase
                    gap_left <= gap;
                    burst_left <= $urandom_range(1, 24);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: its own stall pattern, plus one long hold to back up the input.
    always @(negedge clk)
    begin : drain_pace
        if (rst_n)
        begin
            if (mode_left == 0)
            begin
                rx_mode <= $urandom_range(0, 3);
                mode_left <= $urandom_range(30, 200);
            end
            else
            begin
                mode_left <= mode_left - 1;
            end
            rx_phase <= rx_phase + 1;
            if (!long_hold_done && results_seen >= HOLD_AT)
            begin
                long_hold_done <= 1'b1;
                hold_left <= LONG_HOLD;
                m_axis_tready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                case (rx_mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                    2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: m_axis_tready <= (rx_phase % 3 == 0);
                endcase
            end
        end
    end

    // Results are checked before the new word is predicted, so one queue
    // holds every expectation in order.
    always @(posedge clk)
    begin : scoreboard
        stack_result_t want;
        stack_result_t got;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.status  = m_axis_tdata[2:0];
                got.depth   = m_axis_tdata[9:3];
                got.top_cls = m_axis_tdata[11:10];
                got.top_val = m_axis_tdata[43:12];
                results_seen <= results_seen + 1;
                if (pending_results.size() == 0)
                begin
                    $error("result word with none expected: %h", m_axis_tdata);
                    err_count = err_count + 1;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.status != want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        err_count = err_count + 1;
                    end
                    if (got.depth != want.depth)
                    begin
                        $error("stack_count: expected %0d, got %0d", want.depth, got.depth);
                        err_count = err_count + 1;
                    end
                    if (got.top_cls != want.top_cls)
                    begin
                        $error("top_class: expected %0d, got %0d", want.top_cls, got.top_cls);
                        err_count = err_count + 1;
                    end
                    if (got.top_val != want.top_val)
                    begin
                        $error("top_value: expected %h, got %h", want.top_val, got.top_val);
                        err_count = err_count + 1;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                pending_results.push_back(run_command(CHK_VIEW, s_axis_tuser,
                                                      s_axis_tdata[1:0], s_axis_tdata[33:2]));
                words_in <= words_in + 1;
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial
    begin : stimulus
        int d;
        int n;
        int j;
        int next_full;
        stack_fill[GEN_VIEW] = 0;
        stack_fill[CHK_VIEW] = 0;

        // Every command that can underflow, on an empty stack.
        add_word(CMD_POP, CL_NULL, '0);
        add_word(CMD_EXCH, CL_NULL, '0);
        add_word(CMD_DUP, CL_NULL, '0);
        add_word(CMD_INDEX, CL_NULL, '0);
        add_word(CMD_ROLL, CL_NULL, '0);
        add_word(CMD_CTM, CL_NULL, '0);
        add_word(CMD_CLM, CL_NULL, '0);
        // Every class, extreme values kept as given.
        add_word(CMD_PUSH, CL_NULL, 32'h8000_0000);
        add_word(CMD_PUSH, CL_MARK, 32'h7FFF_FFFF);
        add_word(CMD_PUSH, CL_OTHER, 32'hFFFF_FFFF);
        add_word(CMD_PUSH, CL_NUMBER, 32'd2);
        add_word(CMD_INDEX, CL_NULL, '0);
        // The top is now a null, so index fails on its class.
        add_word(CMD_INDEX, CL_NULL, '0);
        add_word(CMD_PUSH, CL_NUMBER, 32'hFFFF_FFFF);
        add_word(CMD_INDEX, CL_NULL, '0);
        // Roll three elements backward by two.
        add_word(CMD_PUSH, CL_NUMBER, 32'd3);
        add_word(CMD_PUSH, CL_NUMBER, 32'hFFFF_FFFE);
        add_word(CMD_ROLL, CL_NULL, '0);
        add_word(CMD_COUNT, CL_NULL, '0);
        add_word(CMD_CTM, CL_NULL, '0);
        add_word(CMD_CLM, CL_NULL, '0);
        add_word(CMD_SPARE_HI, CL_OTHER, 32'h1234_5678);
        // A shift equal to the count is out of range.
        add_word(CMD_PUSH, CL_NUMBER, 32'd1);
        add_word(CMD_PUSH, CL_NUMBER, 32'd1);
        add_word(CMD_ROLL, CL_NULL, '0);
        add_word(CMD_CLEAR, CL_NULL, '0);

        next_full = 200;
        while (gen_count < N_ITEMS)
        begin
            d = stack_fill[GEN_VIEW];
            if (gen_count >= next_full)
            begin
                // Fill up, roll nearly the whole stack, then provoke overflow.
                next_full = next_full + 420;
                while (stack_fill[GEN_VIEW] < STACK_DEPTH - 2)
                    add_word(CMD_PUSH, rand_class(), rand_value());
                n = STACK_DEPTH - 2;
                add_word(CMD_PUSH, CL_NUMBER, n);
                add_word(CMD_PUSH, CL_NUMBER, $urandom_range(0, 2 * n - 2) - (n - 1));
                add_word(CMD_ROLL, CL_NULL, '0);
                while (stack_fill[GEN_VIEW] < STACK_DEPTH)
                    add_word(CMD_PUSH, rand_class(), rand_value());
                add_word(CMD_PUSH, CL_MARK, rand_value());
                add_word(CMD_DUP, CL_NULL, '0);
                add_word(CMD_COUNT, CL_NULL, '0);
                add_word(CMD_CTM, CL_NULL, '0);
                add_word(CMD_INDEX, CL_NULL, '0);
                add_word($urandom_range(0, 1) ? CMD_CLEAR : CMD_CLM, CL_NULL, '0);
            end
            else if (d >= 52)
            begin
                case ($urandom_range(0, 2))
                    0: add_word(CMD_CLEAR, CL_NULL, '0);
                    1: add_word(CMD_CLM, CL_NULL, '0);
                    default: repeat ($urandom_range(4, 20)) add_word(CMD_POP, CL_NULL, '0);
                endcase
            end
            else
            begin
                case ($urandom_range(0, 19))
                    0, 1, 2: add_word(4'($urandom_range(0, 15)), rand_class(), $urandom());
                    3, 4, 5, 6, 7: add_word(CMD_PUSH, rand_class(), rand_value());
                    8, 9, 10:
                    begin
                        if ($urandom_range(0, 7) == 0) n = rand_value();
                        else n = $urandom_range(0, (d > 0) ? d - 1 : 0);
                        add_word(CMD_PUSH, CL_NUMBER, n);
                        add_word(CMD_INDEX, CL_NULL, '0);
                    end
                    11, 12, 13:
                    begin
                        if (d < 1 || $urandom_range(0, 7) == 0)
                        begin
                            add_word(CMD_PUSH, rand_class(), rand_value());
                            add_word(CMD_PUSH, rand_class(), rand_value());
                        end
                        else
                        begin
                            n = $urandom_range(1, d);
                            j = $urandom_range(0, 2 * n - 2) - (n - 1);
                            add_word(CMD_PUSH, CL_NUMBER, n);
                            add_word(CMD_PUSH, CL_NUMBER, j);
                        end
                        add_word(CMD_ROLL, CL_NULL, '0);
                    end
                    14, 15:
                    begin
                        add_word(CMD_PUSH, CL_MARK, rand_value());
                        repeat ($urandom_range(0, 5))
                            add_word(CMD_PUSH, rand_class(), rand_value());
                        if ($urandom_range(0, 1)) add_word(CMD_CTM, CL_NULL, '0);
                        if ($urandom_range(0, 1)) add_word(CMD_CLM, CL_NULL, '0);
                    end
                    default:
                    begin
                        case ($urandom_range(0, 7))
                            0: add_word(CMD_POP, CL_NULL, '0);
                            1: add_word(CMD_EXCH, CL_NULL, '0);
                            2: add_word(CMD_DUP, CL_NULL, '0);
                            3: add_word(CMD_COUNT, CL_NULL, '0);
                            4: add_word(CMD_CTM, CL_NULL, '0);
                            5: add_word(CMD_CLM, CL_NULL, '0);
                            6: add_word(4'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)),
                                        rand_class(), $urandom());
                            default: add_word(CMD_CLEAR, CL_NULL, '0);
                        endcase
                    end
                endcase
            end
        end

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        while (!(cmd_q.size() == 0 && words_in == words_offered &&
                 pending_results.size() == 0))
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
